// ===== rtl/apu_pkg.sv =====
// shared constants, types and arctangent table for the atan2 phase unwrapper
package apu_pkg;

    // field widths of the sample and result transactions
    localparam int SAMPLE_W = 16;
    localparam int ANG_W    = 17;
    localparam int UNW_W    = 24;
    localparam int TURN_W   = 8;
    localparam int QUAD_W   = 2;
    localparam int LIMIT_W  = 7;

    // cordic sizing
    localparam int CORDIC_STEPS = 16;
    localparam int PHASE_BITS   = 16;
    localparam int GUARD_BITS   = 16;
    localparam int ACC_PI_SHIFT = 31;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam int TBL_DEPTH    = 32;
    localparam int TBL_IDX_W    = $clog2(TBL_DEPTH);
    localparam int TBL_W        = 32;
    localparam int XY_W         = SAMPLE_W + GUARD_BITS + 3;
    localparam int Z_W          = ACC_PI_SHIFT + 3;
    localparam int RND_SH       = ACC_PI_SHIFT + 1 - PHASE_BITS;
    localparam int Q_W          = Z_W - RND_SH;

    // reset value of the turn limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(40);

    // quadrant codes: bit1 real negative, bit0 imaginary negative
    localparam logic [QUAD_W-1:0] QUAD_II  = 2'b10;
    localparam logic [QUAD_W-1:0] QUAD_III = 2'b11;

    // arctan(2^-i) with pi at 2^31
    localparam logic [TBL_W-1:0] ATAN_TABLE [TBL_DEPTH] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              step;
        logic [ITER_W-1:0] iter;
        logic              finish;
    } apu_cmd_t;

endpackage

// ===== rtl/apu_if.sv =====
// sample and result channel interfaces

interface apu_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [apu_pkg::SAMPLE_W-1:0] real_part;
    logic signed [apu_pkg::SAMPLE_W-1:0] imag_part;

    modport source (output valid, real_part, imag_part, input ready);
    modport sink (input valid, real_part, imag_part, output ready);
endinterface

interface apu_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [apu_pkg::UNW_W-1:0]  unwrapped_phase;
    logic signed [apu_pkg::ANG_W-1:0]  wrapped_phase;
    logic signed [apu_pkg::TURN_W-1:0] turn_count;
    logic        [apu_pkg::QUAD_W-1:0] quadrant_code;

    modport source (output valid, unwrapped_phase, wrapped_phase, turn_count, quadrant_code,
                    input ready);
    modport sink (input valid, unwrapped_phase, wrapped_phase, turn_count, quadrant_code,
                  output ready);
endinterface

// ===== rtl/apu_ctrl.sv =====
// controller state machine: sequences load, cordic iterations and result hand-off
module apu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output apu_pkg::apu_cmd_t cmd
);
    import apu_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    // output register can take a new result
    assign out_free = !out_valid_reg || out_ready;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_valid && (state_reg == ST_IDLE);
    assign cmd.step   = (state_reg == ST_RUN);
    assign cmd.iter   = iter_reg;
    assign cmd.finish = (state_reg == ST_FIN) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                iter_next = '0;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/apu_datapath.sv =====
// datapath: cordic vectoring unit, turn tracking and result register
module apu_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  apu_pkg::apu_cmd_t                   cmd,
    input  logic                                cfg_wr_en,
    input  logic        [apu_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic signed [apu_pkg::SAMPLE_W-1:0] real_part,
    input  logic signed [apu_pkg::SAMPLE_W-1:0] imag_part,
    output logic signed [apu_pkg::UNW_W-1:0]    unwrapped_phase,
    output logic signed [apu_pkg::ANG_W-1:0]    wrapped_phase,
    output logic signed [apu_pkg::TURN_W-1:0]   turn_count,
    output logic        [apu_pkg::QUAD_W-1:0]   quadrant_code
);
    import apu_pkg::*;

    localparam logic signed [Z_W-1:0] PI_ACC =
        {{(Z_W - ACC_PI_SHIFT - 1){1'b0}}, 1'b1, {ACC_PI_SHIFT{1'b0}}};
    localparam logic signed [Z_W-1:0] ROUND_HALF =
        {{(Z_W - RND_SH){1'b0}}, 1'b1, {(RND_SH - 1){1'b0}}};
    localparam logic signed [Q_W-1:0] HALF_Q =
        {{(Q_W - PHASE_BITS){1'b0}}, 1'b1, {(PHASE_BITS - 1){1'b0}}};
    localparam logic signed [ANG_W-1:0] HALF_ANG =
        {{(ANG_W - PHASE_BITS){1'b0}}, 1'b1, {(PHASE_BITS - 1){1'b0}}};

    logic signed [XY_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     axis_reg, re_neg_reg;
    logic [QUAD_W-1:0]        quad_reg;
    logic [LIMIT_W-1:0]       limit_reg;
    logic [QUAD_W-1:0]        prev_quad_reg;
    logic                     first_reg;
    logic signed [TURN_W-1:0] turns_reg, turns_next;

    logic signed [UNW_W-1:0]  unw_reg, unw_next;
    logic signed [ANG_W-1:0]  ang_reg, ang_next;
    logic signed [TURN_W-1:0] cnt_reg;
    logic [QUAD_W-1:0]        qout_reg;

    logic signed [XY_W-1:0]   re_scaled, im_scaled, dx, dy;
    logic signed [Z_W-1:0]    atan_z, z_round;
    logic signed [Q_W-1:0]    q_val, q_clamp;
    logic signed [TURN_W:0]   t_sum;
    logic        [TURN_W:0]   t_abs;

    // scaled samples and the per-iteration shifts
    assign re_scaled = XY_W'(real_part) <<< GUARD_BITS;
    assign im_scaled = XY_W'(imag_part) <<< GUARD_BITS;
    assign dx        = y_reg >>> cmd.iter;
    assign dy        = x_reg >>> cmd.iter;
    assign atan_z    = $signed({{(Z_W - TBL_W){1'b0}}, ATAN_TABLE[TBL_IDX_W'(cmd.iter)]});

    // cordic vector registers: pre-rotation by pi on load when the real part is negative, one iteration per step
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (cmd.load)
        begin
            if (real_part[SAMPLE_W-1])
            begin
                x_next = -re_scaled;
                y_next = -im_scaled;
                z_next = imag_part[SAMPLE_W-1] ? -PI_ACC : PI_ACC;
            end
            else
            begin
                x_next = re_scaled;
                y_next = im_scaled;
                z_next = '0;
            end
        end
        else if (cmd.step)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + atan_z;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - atan_z;
            end
        end
    end

    // round the angle to phase units and clamp to plus or minus pi; samples on the real axis give 0 or pi
    assign z_round = z_reg + ROUND_HALF;
    assign q_val   = z_round[Z_W-1:RND_SH];
    always_comb
    begin
        q_clamp = q_val;
        if (q_val > HALF_Q)
        begin
            q_clamp = HALF_Q;
        end
        else if (q_val < -HALF_Q)
        begin
            q_clamp = -HALF_Q;
        end
        if (axis_reg)
        begin
            ang_next = re_neg_reg ? HALF_ANG : '0;
        end
        else
        begin
            ang_next = q_clamp[ANG_W-1:0];
        end
    end

    // turn count update on quadrant crossings between III and II, cleared past the limit, and the unwrapped phase
    always_comb
    begin
        t_sum = {turns_reg[TURN_W-1], turns_reg};
        if (!first_reg)
        begin
            if (prev_quad_reg == QUAD_III && quad_reg == QUAD_II)
            begin
                t_sum = t_sum - 1'b1;
            end
            else if (prev_quad_reg == QUAD_II && quad_reg == QUAD_III)
            begin
                t_sum = t_sum + 1'b1;
            end
        end
        t_abs = t_sum[TURN_W] ? -t_sum : t_sum;
        if (t_abs > {2'b00, limit_reg})
        begin
            turns_next = '0;
        end
        else
        begin
            turns_next = t_sum[TURN_W-1:0];
        end
        unw_next = {{(UNW_W - ANG_W){ang_next[ANG_W-1]}}, ang_next}
                 + {turns_next, {PHASE_BITS{1'b0}}};
    end

    // cordic, sample and result registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (cmd.load)
        begin
            axis_reg   <= (imag_part == '0);
            re_neg_reg <= real_part[SAMPLE_W-1];
            quad_reg   <= {real_part[SAMPLE_W-1], imag_part[SAMPLE_W-1]};
        end
        if (cmd.finish)
        begin
            unw_reg  <= unw_next;
            ang_reg  <= ang_next;
            cnt_reg  <= turns_next;
            qout_reg <= quad_reg;
        end
    end

    // limit register and turn tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            prev_quad_reg <= '0;
            first_reg     <= 1'b1;
            turns_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.finish)
            begin
                prev_quad_reg <= quad_reg;
                first_reg     <= 1'b0;
                turns_reg     <= turns_next;
            end
        end
    end

    assign unwrapped_phase = unw_reg;
    assign wrapped_phase   = ang_reg;
    assign turn_count      = cnt_reg;
    assign quadrant_code   = qout_reg;

endmodule

// ===== rtl/atan2_phase_unwrapper.sv =====
// top level: cordic atan2 with turn unwrapping, 16 iterations on one shared stage
// sequence: load, 16 cordic iterations through the one shift-add stage, then a rounding
// and unwrap step that writes the output register once it is free
// a new sample is taken only when idle; a finished result waits in the
// output register while the next sample is taken
// reset: asynchronous active low; turn limit 40, turn count 0, first sample pending
module atan2_phase_unwrapper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [apu_pkg::LIMIT_W-1:0]        cfg_wr_data,
    apu_sample_if.sink                         sample,
    apu_result_if.source                       result
);
    import apu_pkg::*;

    apu_cmd_t cmd;

    // control
    apu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // datapath
    apu_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .real_part       (sample.real_part),
        .imag_part       (sample.imag_part),
        .unwrapped_phase (result.unwrapped_phase),
        .wrapped_phase   (result.wrapped_phase),
        .turn_count      (result.turn_count),
        .quadrant_code   (result.quadrant_code)
    );

`ifndef ASSERT_OFF
    // a finished computation always lands in the output register
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> result.valid)
        else $error("finish did not produce a valid result");

    // an accepted sample keeps the input closed during the iterations
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample accepted while cordic busy");

    // the wrapped angle stays within plus or minus pi
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.wrapped_phase <= 17'sd32768
                          && result.wrapped_phase >= -17'sd32768))
        else $error("wrapped phase out of range");

    // the turn count never reaches the most negative code
    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.turn_count != -8'sd128))
        else $error("turn count out of range");
`endif

endmodule

// ===== test/tb_atan2_phase_unwrapper.sv =====
// self-checking testbench for the atan2 phase unwrapper: random handshakes, cordic and turn predictor
module tb_atan2_phase_unwrapper;
    import apu_pkg::*;

    // quadrant codes not named in the package
    localparam logic [QUAD_W-1:0] QUAD_I  = 2'b00;
    localparam logic [QUAD_W-1:0] QUAD_IV = 2'b01;

    // angle constants, pi at 2^31 in the accumulator and 2^15 at the output
    localparam longint ACC_HALF_TURN = longint'(1) << ACC_PI_SHIFT;
    localparam longint OUT_HALF_TURN = longint'(1) << (PHASE_BITS - 1);

    // arctan(2^-i) steps with pi at 2^31
    localparam longint ARCTAN_STEP [CORDIC_STEPS] = '{
        'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
        'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
        'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
    } sample_t;

    typedef struct packed {
        logic signed [UNW_W-1:0]  unwrapped;
        logic signed [ANG_W-1:0]  wrapped;
        logic signed [TURN_W-1:0] turns;
        logic        [QUAD_W-1:0] quad;
    } phase_result_t;

    // clock, reset and block inputs, all known from time zero
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]        cfg_wr_data = '0;
    logic                      drv_valid = 1'b0;
    logic signed [SAMPLE_W-1:0] drv_real = '0;
    logic signed [SAMPLE_W-1:0] drv_imag = '0;
    logic                      res_ready = 1'b0;

    // predictor state
    logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;
    logic [QUAD_W-1:0]  last_quad = QUAD_I;
    bit                 awaiting_first = 1'b1;
    int                 turn_total = 0;

    sample_t       samples_pending[$];
    phase_result_t phase_expected[$];
    phase_result_t phase_head;
    phase_result_t phase_got;
    int            err_count = 0;
    bit            calm = 1'b0;

    apu_sample_if sample_ch();
    apu_result_if result_ch();

    assign sample_ch.valid     = drv_valid;
    assign sample_ch.real_part = drv_real;
    assign sample_ch.imag_part = drv_imag;
    assign result_ch.ready     = res_ready;

    atan2_phase_unwrapper DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .sample     (sample_ch),
        .result     (result_ch)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // percent of cycles each side sits idle
    function automatic int idle_pct();
        return calm ? 0 : 21;
    endfunction

    // vectoring cordic angle, pi at 2^15
    function automatic logic signed [ANG_W-1:0] cordic_phase(logic signed [SAMPLE_W-1:0] re,
                                                            logic signed [SAMPLE_W-1:0] im);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint q;
        if (re == 0 && im == 0)
            return '0;
        if (im == 0)
            return (re < 0) ? ANG_W'(OUT_HALF_TURN) : '0;
        x = longint'(re) * (longint'(1) << GUARD_BITS);
        y = longint'(im) * (longint'(1) << GUARD_BITS);
        z = 0;
        // left half plane: rotate by pi first
        if (re < 0)
        begin
            x = -x;
            y = -y;
            z = (im > 0) ? ACC_HALF_TURN : -ACC_HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end
        end
        // round half up to output units, clamp to +-pi
        q = (z + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
        if (q > OUT_HALF_TURN)
            q = OUT_HALF_TURN;
        if (q < -OUT_HALF_TURN)
            q = -OUT_HALF_TURN;
        return ANG_W'(q);
    endfunction

    // angle plus turn bookkeeping for one accepted sample
    function automatic void predict_phase(logic signed [SAMPLE_W-1:0] re,
                                          logic signed [SAMPLE_W-1:0] im);
        phase_result_t r;
        logic [QUAD_W-1:0] quad;
        longint angle;
        int t;
        int mag;
        angle = longint'(cordic_phase(re, im));
        quad = {re < 0, im < 0};
        t = turn_total;
        if (awaiting_first)
            awaiting_first = 1'b0;
        else if (quad == QUAD_II && last_quad == QUAD_III)
            t = t - 1;
        else if (quad == QUAD_III && last_quad == QUAD_II)
            t = t + 1;
        last_quad = quad;
        mag = (t < 0) ? -t : t;
        if (mag > int'(limit_now))
            t = 0;
        turn_total = t;
        r.unwrapped = UNW_W'(angle + longint'(t) * (longint'(1) << PHASE_BITS));
        r.wrapped   = ANG_W'(angle);
        r.turns     = TURN_W'(t);
        r.quad      = quad;
        phase_expected.push_back(r);
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (drv_valid && sample_ch.ready)
                predict_phase(drv_real, drv_imag);
            if (!drv_valid || sample_ch.ready)
            begin
                if (samples_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct())
                begin
                    drv_valid <= 1'b1;
                    drv_real  <= samples_pending[0].re;
                    drv_imag  <= samples_pending[0].im;
                    void'(samples_pending.pop_front());
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && res_ready)
            begin
                phase_got = {result_ch.unwrapped_phase, result_ch.wrapped_phase,
                             result_ch.turn_count, result_ch.quadrant_code};
                if (phase_expected.size() == 0)
                begin
                    $display("%0t: unexpected transaction: unwrapped %0d wrapped %0d turns %0d quad %0d",
                             $time, phase_got.unwrapped, phase_got.wrapped, phase_got.turns,
                             phase_got.quad);
                    err_count++;
                end
                else
                begin
                    phase_head = phase_expected.pop_front();
                    if (phase_got !== phase_head)
                    begin
                        $display("%0t: mismatch: expected unwrapped %0d wrapped %0d turns %0d quad %0d",
                                 $time, phase_head.unwrapped, phase_head.wrapped,
                                 phase_head.turns, phase_head.quad);
                        $display("%0t:           actual unwrapped %0d wrapped %0d turns %0d quad %0d",
                                 $time, phase_got.unwrapped, phase_got.wrapped,
                                 phase_got.turns, phase_got.quad);
                        err_count++;
                    end
                end
            end
            res_ready <= ($urandom_range(0, 99) >= idle_pct());
        end
    end

    // one signed component, biased toward the extremes and small values
    function automatic logic signed [SAMPLE_W-1:0] pick_part(bit neg);
        int mag;
        case ($urandom_range(0, 9))
            0: mag = neg ? 32767 : 0;
            1: mag = neg ? 0 : 32767;
            2: mag = $urandom_range(0, 15);
            default: mag = $urandom_range(0, 32767);
        endcase
        return neg ? SAMPLE_W'(-1 - mag) : SAMPLE_W'(mag);
    endfunction

    task automatic push_sample(int re, int im);
        sample_t s;
        s.re = SAMPLE_W'(re);
        s.im = SAMPLE_W'(im);
        samples_pending.push_back(s);
    endtask

    task automatic push_in_quad(logic [QUAD_W-1:0] quad);
        sample_t s;
        s.re = pick_part(quad[1]);
        s.im = pick_part(quad[0]);
        samples_pending.push_back(s);
    endtask

    // raw or quadrant-shaped random samples
    task automatic push_noise(int n);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_sample($urandom, $urandom);
            else
                push_in_quad(QUAD_W'($urandom_range(0, 3)));
        end
    endtask

    // rotating phasor crossing the negative real axis once per turn
    task automatic push_spin(bit up, int turns, bit tight);
        for (int k = 0; k < turns; k++)
        begin
            push_in_quad(up ? QUAD_II : QUAD_III);
            push_in_quad(up ? QUAD_III : QUAD_II);
            if (tight)
            begin
                push_in_quad($urandom_range(0, 1) ? QUAD_I : QUAD_IV);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    push_in_quad(up ? QUAD_IV : QUAD_I);
                if ($urandom_range(0, 3) != 0)
                    push_in_quad(up ? QUAD_I : QUAD_IV);
            end
        end
    endtask

    // wait until every sample is sent and every result is back
    task automatic drain();
        while (samples_pending.size() != 0 || drv_valid || phase_expected.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_now = v;
    endtask

    // watchdog
    initial
    begin
        #5000000;
        $display("tb_atan2_phase_unwrapper: errors");
        $finish;
    end

    // stimulus phases
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, zero sample, real axis, axis crossings
        push_sample(-32768, -32768);
        push_sample(-1, 1);
        push_sample(0, 0);
        push_sample(32767, 0);
        push_sample(-32768, 0);
        push_sample(-1, 0);
        push_sample(0, 32767);
        push_sample(0, -32768);
        push_sample(32767, 32767);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        push_sample(1, 1);
        push_sample(-1, -1);
        push_sample(1, -1);
        push_sample(-32768, 1);
        push_sample(-32768, -1);
        push_sample(-100, 5);
        push_sample(-7, -9);
        push_sample(0, 0);
        push_sample(-3, 2);
        push_sample(-3, -2);
        push_sample(5, -5);
        push_sample(-32767, 32767);
        drain();

        // limit zero clears every count
        write_limit('0);
        push_noise(15);
        push_spin(1'b1, 3, 1'b0);
        push_spin(1'b0, 2, 1'b0);
        drain();

        // limit of one, no idling on either side
        calm = 1'b1;
        write_limit(LIMIT_W'(1));
        for (int k = 0; k < 3; k++)
        begin
            push_spin($urandom_range(0, 1), $urandom_range(1, 4), $urandom_range(0, 1));
            push_noise($urandom_range(0, 4));
        end
        drain();
        calm = 1'b0;

        // highest limit, run the count past it
        write_limit(LIMIT_W'(127));
        push_spin(1'b1, 130, 1'b1);
        push_noise(10);
        push_spin(1'b0, 5, 1'b1);
        drain();

        // assorted small limits with spins both ways
        write_limit(LIMIT_W'($urandom_range(2, 12)));
        for (int k = 0; k < 3; k++)
        begin
            push_spin($urandom_range(0, 1), $urandom_range(1, 4), $urandom_range(0, 1));
            push_noise($urandom_range(0, 6));
        end
        drain();

        if (err_count == 0 && phase_expected.size() == 0)
            $display("tb_atan2_phase_unwrapper: clean");
        else
            $display("tb_atan2_phase_unwrapper: errors");
        $finish;
    end

endmodule
